>>> hw/rtl/hcs_pkg.sv
// Package for the chained hash set: sizes, widths, opcodes and the controller state type.
// Used by hcs_mod and chained_hash_set; depends on nothing else.
package hcs_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_NODES  = 2048;

    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int BC_W    = 11;
    localparam int CNT_W   = 12;
    localparam int REF_W   = $clog2(POOL_NODES + 1);
    localparam int NODE_AW = $clog2(POOL_NODES);
    localparam int HEAD_AW = $clog2(MAX_BUCKETS);
    localparam int NODE_W  = KEY_W + REF_W;
    localparam int MOD_DIGIT = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [BC_W-1:0] BC_RESET = 11'd1021;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_WALK,
        ST_NODE,
        ST_ACT,
        ST_FREE,
        ST_UNLINK,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/hcs_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; every memory of the hash set is an instance of it.
module hcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/hcs_mod.sv
// Iterative remainder unit: key modulo bucket count, four quotient bits a cycle.
// Depends on hcs_pkg.
module hcs_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [hcs_pkg::KEY_W-1:0]   dividend,
    input  logic [hcs_pkg::BC_W-1:0]    divisor,
    output logic                        done,
    output logic [hcs_pkg::HEAD_AW-1:0] remainder
);

    localparam int STEPS = hcs_pkg::KEY_W / hcs_pkg::MOD_DIGIT;
    localparam int CW    = $clog2(STEPS + 1);

    logic [hcs_pkg::KEY_W-1:0] shift_reg;
    logic [hcs_pkg::BC_W-1:0]  div_reg;
    logic [hcs_pkg::BC_W-1:0]  rem_reg;
    logic [hcs_pkg::BC_W-1:0]  rem_next;
    logic [CW-1:0]             cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    always_comb
    begin
        logic [hcs_pkg::BC_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < hcs_pkg::MOD_DIGIT; i++)
        begin
            r = {r[hcs_pkg::BC_W-1:0], shift_reg[hcs_pkg::KEY_W-1-i]};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[hcs_pkg::BC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << hcs_pkg::MOD_DIGIT;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[hcs_pkg::HEAD_AW-1:0];

endmodule

>>> hw/rtl/chained_hash_set.sv
// Chained hash set top level: request controller, bucket head RAM and node RAM.
// Depends on hcs_pkg, hcs_ram and hcs_mod.
// Each request hashes the key, reads the bucket head and walks the chain node by node;
// a free-list insert or an erase that hits passes through one more state (ST_FREE or ST_UNLINK).
// A new request beat is taken only in the idle state, once the previous response has been registered.
// After reset the bucket heads are cleared with no request beat taken.
module chained_hash_set (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,     // bucket_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // operation[1:0], key[33:2], zero[39:34]
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata       // success[0], element_count[12:1], pool_full[13]
);

    localparam int RW = hcs_pkg::REF_W;
    localparam int KW = hcs_pkg::KEY_W;

    hcs_pkg::state_t state_reg, state_next;

    logic [hcs_pkg::BC_W-1:0]    bc_reg;
    logic [hcs_pkg::BC_W-1:0]    bc_eff;
    logic [hcs_pkg::HEAD_AW-1:0] clr_reg, clr_next;
    logic [hcs_pkg::OP_W-1:0]    op_reg;
    logic [KW-1:0]               key_reg;
    logic [hcs_pkg::HEAD_AW-1:0] bucket_reg, bucket_next;
    logic [RW-1:0]               headval_reg, headval_next;
    logic [RW-1:0]               cur_reg, cur_next;
    logic [RW-1:0]               prev_reg, prev_next;
    logic [KW-1:0]               prevkey_reg, prevkey_next;
    logic [RW-1:0]               hit_reg, hit_next;
    logic [RW-1:0]               hitlink_reg, hitlink_next;
    logic [RW-1:0]               steps_reg, steps_next;
    logic [RW-1:0]               free_reg, free_next;
    logic [RW-1:0]               fresh_reg, fresh_next;
    logic [hcs_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        ok_reg, ok_next;
    logic                        full_reg, full_next;
    logic                        mvalid_reg, mvalid_next;
    logic [15:0]                 mdata_reg, mdata_next;

    logic                        head_we;
    logic [hcs_pkg::HEAD_AW-1:0] head_addr;
    logic [RW-1:0]               head_wdata, head_rdata;
    logic                        node_we;
    logic [hcs_pkg::NODE_AW-1:0] node_addr;
    logic [hcs_pkg::NODE_W-1:0]  node_wdata, node_rdata;
    logic [KW-1:0]               node_key;
    logic [RW-1:0]               node_link;

    logic                        mod_start, mod_done;
    logic [hcs_pkg::HEAD_AW-1:0] mod_rem;
    logic                        accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == hcs_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign mod_start = accept;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign node_key  = node_rdata[KW-1:0];
    assign node_link = node_rdata[hcs_pkg::NODE_W-1:KW];

    always_comb
    begin
        if (bc_reg == '0)
        begin
            bc_eff = hcs_pkg::BC_W'(1);
        end
        else if (bc_reg > hcs_pkg::BC_W'(hcs_pkg::MAX_BUCKETS))
        begin
            bc_eff = hcs_pkg::BC_W'(hcs_pkg::MAX_BUCKETS);
        end
        else
        begin
            bc_eff = bc_reg;
        end
    end

    hcs_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (s_tdata[33:2]),
        .divisor   (bc_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    hcs_ram #(.WIDTH(RW), .DEPTH(hcs_pkg::MAX_BUCKETS)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .addr  (head_addr),
        .wdata (head_wdata),
        .rdata (head_rdata)
    );

    hcs_ram #(.WIDTH(hcs_pkg::NODE_W), .DEPTH(hcs_pkg::POOL_NODES)) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_wdata),
        .rdata (node_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        bucket_next  = bucket_reg;
        headval_next = headval_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        prevkey_next = prevkey_reg;
        hit_next     = hit_reg;
        hitlink_next = hitlink_reg;
        steps_next   = steps_reg;
        free_next    = free_reg;
        fresh_next   = fresh_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        full_next    = full_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        head_we      = 1'b0;
        head_addr    = bucket_reg;
        head_wdata   = '0;
        node_we      = 1'b0;
        node_addr    = '0;
        node_wdata   = '0;

        unique case (state_reg)
            hcs_pkg::ST_CLEAR:
            begin
                head_we   = 1'b1;
                head_addr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == hcs_pkg::HEAD_AW'(hcs_pkg::MAX_BUCKETS - 1))
                begin
                    state_next = hcs_pkg::ST_IDLE;
                end
            end
            hcs_pkg::ST_IDLE:
            begin
                ok_next   = 1'b0;
                full_next = 1'b0;
                if (accept)
                begin
                    state_next = hcs_pkg::ST_HASH;
                end
            end
            hcs_pkg::ST_HASH:
            begin
                head_addr = mod_rem;
                if (mod_done)
                begin
                    bucket_next = mod_rem;
                    state_next  = hcs_pkg::ST_HEAD;
                end
            end
            hcs_pkg::ST_HEAD:
            begin
                headval_next = head_rdata;
                cur_next     = head_rdata;
                prev_next    = '0;
                hit_next     = '0;
                steps_next   = '0;
                state_next   = hcs_pkg::ST_WALK;
            end
            hcs_pkg::ST_WALK:
            begin
                node_addr = hcs_pkg::NODE_AW'(cur_reg - 1'b1);
                if (cur_reg != '0 && cur_reg <= RW'(hcs_pkg::POOL_NODES)
                    && steps_reg < RW'(hcs_pkg::POOL_NODES))
                begin
                    state_next = hcs_pkg::ST_NODE;
                end
                else
                begin
                    state_next = hcs_pkg::ST_ACT;
                end
            end
            hcs_pkg::ST_NODE:
            begin
                if (node_key == key_reg)
                begin
                    hit_next     = cur_reg;
                    hitlink_next = node_link;
                    state_next   = hcs_pkg::ST_ACT;
                end
                else
                begin
                    prev_next    = cur_reg;
                    prevkey_next = node_key;
                    cur_next     = node_link;
                    steps_next   = steps_reg + 1'b1;
                    state_next   = hcs_pkg::ST_WALK;
                end
            end
            hcs_pkg::ST_ACT:
            begin
                state_next = hcs_pkg::ST_DONE;
                case (op_reg)
                    hcs_pkg::OP_INSERT:
                    begin
                        if (hit_reg == '0)
                        begin
                            if (free_reg != '0 && free_reg <= RW'(hcs_pkg::POOL_NODES))
                            begin
                                node_addr  = hcs_pkg::NODE_AW'(free_reg - 1'b1);
                                state_next = hcs_pkg::ST_FREE;
                            end
                            else if (fresh_reg < RW'(hcs_pkg::POOL_NODES))
                            begin
                                node_we    = 1'b1;
                                node_addr  = fresh_reg[hcs_pkg::NODE_AW-1:0];
                                node_wdata = {headval_reg, key_reg};
                                head_we    = 1'b1;
                                head_wdata = fresh_reg + 1'b1;
                                fresh_next = fresh_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                                ok_next    = 1'b1;
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                    end
                    hcs_pkg::OP_ERASE:
                    begin
                        if (hit_reg != '0)
                        begin
                            if (prev_reg == '0)
                            begin
                                head_we    = 1'b1;
                                head_wdata = hitlink_reg;
                            end
                            else
                            begin
                                node_we    = 1'b1;
                                node_addr  = hcs_pkg::NODE_AW'(prev_reg - 1'b1);
                                node_wdata = {hitlink_reg, prevkey_reg};
                            end
                            state_next = hcs_pkg::ST_UNLINK;
                        end
                    end
                    hcs_pkg::OP_QUERY:
                    begin
                        ok_next = (hit_reg != '0);
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            hcs_pkg::ST_FREE:
            begin
                node_we    = 1'b1;
                node_addr  = hcs_pkg::NODE_AW'(free_reg - 1'b1);
                node_wdata = {headval_reg, key_reg};
                head_we    = 1'b1;
                head_wdata = free_reg;
                free_next  = node_link;
                count_next = count_reg + 1'b1;
                ok_next    = 1'b1;
                state_next = hcs_pkg::ST_DONE;
            end
            hcs_pkg::ST_UNLINK:
            begin
                node_we    = 1'b1;
                node_addr  = hcs_pkg::NODE_AW'(hit_reg - 1'b1);
                node_wdata = {free_reg, key_reg};
                free_next  = hit_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                ok_next    = 1'b1;
                state_next = hcs_pkg::ST_DONE;
            end
            hcs_pkg::ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {2'b00, full_reg, count_reg, ok_reg};
                    state_next  = hcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hcs_pkg::ST_CLEAR;
            clr_reg    <= '0;
            bc_reg     <= hcs_pkg::BC_RESET;
            free_reg   <= '0;
            fresh_reg  <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid)
            begin
                bc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
        end
        bucket_reg  <= bucket_next;
        headval_reg <= headval_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        prevkey_reg <= prevkey_next;
        hit_reg     <= hit_next;
        hitlink_reg <= hitlink_next;
        steps_reg   <= steps_next;
        ok_reg      <= ok_next;
        full_reg    <= full_next;
        mdata_reg   <= mdata_next;
    end

endmodule
